### rtl/mdf_pkg.sv
// ----------------------------------------------------------------------------
// Message deframer package
// Shared constants and types for the message deframer.
// ----------------------------------------------------------------------------
package mdf_pkg;

    // Width of the length header value and of the payload down counter.
    localparam int LENGTH_WIDTH = 16;

    // Character codes that the parser recognizes.
    localparam logic [7:0] COLON_CHAR   = 8'h3A;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_NINE   = 8'h39;

    // Framing mode codes.
    localparam logic MODE_LENGTH  = 1'b0;
    localparam logic MODE_NEWLINE = 1'b1;

    // One result of the parser for one received byte.
    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       end_of_message;
        logic       malformed_header;
    } mdf_result_t;

endpackage

### rtl/mdf_core.sv
// ----------------------------------------------------------------------------
// Message deframer parser core
// Holds the header and payload state and works out the result for each
// accepted byte in one pass.
// ----------------------------------------------------------------------------
module mdf_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                framing_mode,
    input  logic                rx_accept,
    input  logic [7:0]          rx_byte,
    output mdf_pkg::mdf_result_t result
);
    import mdf_pkg::*;

    localparam int ACC_WIDTH = LENGTH_WIDTH + 4;

    logic                    in_payload_reg, in_payload_next;
    logic [LENGTH_WIDTH-1:0] length_reg, length_next;
    logic                    header_bad_reg, header_bad_next;
    logic                    has_digit_reg, has_digit_next;

    logic [LENGTH_WIDTH-1:0] remaining;
    logic [ACC_WIDTH-1:0]    acc_value;
    logic                    is_digit;

    // Shared datapath terms: count down and digit accumulate (x*10 + d).
    assign remaining = (length_reg == '0) ? '0 : length_reg - 1'b1;
    assign is_digit  = (rx_byte >= DIGIT_ZERO) && (rx_byte <= DIGIT_NINE);
    assign acc_value = ({4'b0, length_reg} << 3) + ({4'b0, length_reg} << 1)
                     + ACC_WIDTH'(rx_byte - DIGIT_ZERO);

    // Next state and result for the byte at the input.
    always_comb
    begin
        in_payload_next = in_payload_reg;
        length_next     = length_reg;
        header_bad_next = header_bad_reg;
        has_digit_next  = has_digit_reg;
        result          = '0;

        if (framing_mode == MODE_NEWLINE)
        begin
            // Newline mode leaves the length-mode state alone.
            result.valid = 1'b1;
            if (rx_byte == NEWLINE_CHAR)
            begin
                result.end_of_message = 1'b1;
            end
            else
            begin
                result.payload_byte = rx_byte;
                result.has_byte     = 1'b1;
            end
        end
        else if (in_payload_reg)
        begin
            result.valid        = 1'b1;
            result.payload_byte = rx_byte;
            result.has_byte     = 1'b1;
            length_next         = remaining;
            if (remaining == '0)
            begin
                in_payload_next       = 1'b0;
                header_bad_next       = 1'b0;
                has_digit_next        = 1'b0;
                result.end_of_message = 1'b1;
            end
        end
        else if (rx_byte == COLON_CHAR)
        begin
            if (header_bad_reg || !has_digit_reg)
            begin
                // Empty or bad header is reported and dropped.
                length_next             = '0;
                header_bad_next         = 1'b0;
                has_digit_next          = 1'b0;
                result.valid            = 1'b1;
                result.malformed_header = 1'b1;
            end
            else if (length_reg == '0)
            begin
                // A zero length gives nothing and restarts the header.
                header_bad_next = 1'b0;
                has_digit_next  = 1'b0;
            end
            else
            begin
                in_payload_next = 1'b1;
                header_bad_next = 1'b0;
                has_digit_next  = 1'b0;
            end
        end
        else if (is_digit)
        begin
            has_digit_next = 1'b1;
            if (!header_bad_reg)
            begin
                if (acc_value[ACC_WIDTH-1:LENGTH_WIDTH] != '0)
                begin
                    header_bad_next = 1'b1;
                end
                else
                begin
                    length_next = acc_value[LENGTH_WIDTH-1:0];
                end
            end
        end
        else
        begin
            header_bad_next = 1'b1;
        end

        if (!rx_accept)
        begin
            result.valid = 1'b0;
        end
    end

    // Parser state registers, updated on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            length_reg     <= '0;
            header_bad_reg <= 1'b0;
            has_digit_reg  <= 1'b0;
        end
        else if (rx_accept)
        begin
            in_payload_reg <= in_payload_next;
            length_reg     <= length_next;
            header_bad_reg <= header_bad_next;
            has_digit_reg  <= has_digit_next;
        end
    end

    // While in payload the count is never zero and the header flags are clear.
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (length_reg != '0))
        else $error("payload state with zero remaining count");

    a_payload_flags: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (!header_bad_reg && !has_digit_reg))
        else $error("header flags set during payload");

    // Newline mode must not disturb the length-mode state.
    a_newline_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_accept && framing_mode == MODE_NEWLINE) |=>
        ($stable(in_payload_reg) && $stable(length_reg) && $stable(header_bad_reg)))
        else $error("newline mode changed length-mode state");

    // The last payload byte ends the message and leaves the payload state.
    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_accept && framing_mode == MODE_LENGTH && in_payload_reg
         && length_reg == LENGTH_WIDTH'(1)) |=> !in_payload_reg)
        else $error("payload state kept after last byte");

endmodule

### rtl/message_deframer.sv
// ----------------------------------------------------------------------------
// Message deframer
// Splits a received byte stream into length-prefixed or newline-separated
// messages and streams the payload bytes out as they arrive.
// ----------------------------------------------------------------------------
// A result is registered and appears on m_tvalid in the cycle after its input transaction.
// Throughput: one byte per cycle; the parser does its whole step in one pass
// between the input handshake and the output register.
// A stalled output holds the input off only while the output register is full.
// Reset clears the mode to length framing, the parser to header state, and
// empties the output register.
// ----------------------------------------------------------------------------
module message_deframer (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,      // framing_mode
    // Input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,          // [7:0] rx_byte
    // Output stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,          // [7:0] payload_byte
    output logic       m_tlast,          // end_of_message
    output logic [1:0] m_tuser           // [0] has_byte, [1] malformed_header
);
    import mdf_pkg::*;

    logic        framing_mode_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_has_reg;
    logic        out_eom_reg;
    logic        out_mal_reg;
    logic        rx_accept;
    mdf_result_t result;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            framing_mode_reg <= MODE_LENGTH;
        end
        else if (cfg_wr_en)
        begin
            framing_mode_reg <= cfg_wr_data;
        end
    end

    // Input is taken whenever the output register is free or being drained.
    assign s_tready  = !out_valid_reg || m_tready;
    assign rx_accept = s_tvalid && s_tready;

    mdf_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .framing_mode (framing_mode_reg),
        .rx_accept    (rx_accept),
        .rx_byte      (s_tdata),
        .result       (result)
    );

    // Output register occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rx_accept)
        begin
            out_valid_next = result.valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, loaded with each new result.
    always_ff @(posedge clk)
    begin
        if (rx_accept && result.valid)
        begin
            out_byte_reg <= result.payload_byte;
            out_has_reg  <= result.has_byte;
            out_eom_reg  <= result.end_of_message;
            out_mal_reg  <= result.malformed_header;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_eom_reg;
    assign m_tuser  = {out_mal_reg, out_has_reg};

endmodule
